// ----- rtl/cplr_pkg.sv -----
package cplr_pkg;

    // One input item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       tx_end;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [1:0] dest;
        logic [7:0] out_byte;
        logic       run_last;
        logic       error_event;
        logic       frame_accepted;
        logic       no_packet;
    } t_out;

    // Item kinds.
    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_TX   = 2'd2;

    // Result destinations.
    localparam logic [1:0] DEST_STATUS = 2'd0;
    localparam logic [1:0] DEST_LINK   = 2'd1;
    localparam logic [1:0] DEST_APP    = 2'd2;

    // Receive framing phases.
    localparam logic [1:0] PH_CMD   = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_ACK_CODE  = 1'b0;
    localparam logic CFG_RETX_CODE = 1'b1;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // CRC-8 of one byte from a zero register: eight shift steps.
    function automatic logic [7:0] crc8(input logic [7:0] x);
        logic [7:0] r;
        r = x;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- rtl/cplr_ram.sv -----
module cplr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/crc8_packet_link_receiver.sv -----
// Link bytes that do not close a frame, and kind 3 items, finish in the accept cycle.
// Single results (link byte, status) appear in the cycle after the item is accepted.
// Sent packets give one result per cycle (3 or 4 results) through the shared CRC unit.
// Ring reads and retransmits alternate a fetch state and an emit state per byte from the registered RAM port.
// Results cannot be stalled; busy is high while a multi-result run is being emitted.
// Synchronous active-low reset; the ring and last-packet memories are not cleared.
module crc8_packet_link_receiver #(
    parameter int MAX_PAYLOAD = 32,
    parameter int RING_SLOTS  = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  cplr_pkg::t_in   i_item,
    output logic            o_strobe,
    output cplr_pkg::t_out  o_result,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [7:0]      i_cfg_data
);
    import cplr_pkg::*;

    localparam int SLOT_BYTES = MAX_PAYLOAD + 3;
    localparam int RING_DEPTH = RING_SLOTS * SLOT_BYTES;
    localparam int RAW = $clog2(RING_DEPTH);
    localparam int LAW = $clog2(SLOT_BYTES);
    localparam int IW  = $clog2(SLOT_BYTES + 1);
    localparam int LW  = $clog2(MAX_PAYLOAD + 1);
    localparam int SW  = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHORT = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [LW-1:0] r_pcount, n_pcount;
    logic [7:0]    r_fcmd, n_fcmd;
    logic [LW-1:0] r_flen, n_flen;
    logic [7:0]    r_hcrc, n_hcrc;
    logic [7:0]    r_pcrc, n_pcrc;
    logic [SW-1:0] r_wslot, n_wslot;
    logic [SW-1:0] r_rslot, n_rslot;
    logic [IW-1:0] r_last_len, n_last_len;
    logic [IW-1:0] r_tx_count, n_tx_count;
    logic [7:0]    r_ack_code, n_ack_code;
    logic [7:0]    r_retx_code, n_retx_code;
    logic [7:0]    r_sh_cmd, n_sh_cmd;
    logic          r_sh_len1, n_sh_len1;
    logic [7:0]    r_sh_pay, n_sh_pay;
    logic [7:0]    r_sck, n_sck;
    logic          r_err, n_err;
    logic          r_acc, n_acc;
    logic          r_src_last, n_src_last;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [RAW-1:0] r_base, n_base;
    logic          r_strobe, n_strobe;
    t_out          r_out, n_out;

    logic           w_accept;
    logic [7:0]     w_b;
    logic [7:0]     w_crc_in, w_crc_out;
    logic [RAW-1:0] w_wbase;
    logic [SW-1:0]  w_wnext;
    logic [7:0]     w_sh_byte;
    logic           w_sh_last;
    logic           w_ring_we;
    logic [RAW-1:0] w_ring_waddr, w_ring_raddr;
    logic [7:0]     w_ring_wdata, w_ring_q;
    logic           w_last_we;
    logic [LAW-1:0] w_last_waddr;
    logic [7:0]     w_last_wdata, w_last_q;
    logic [IW-1:0]  w_tx_next;
    logic [LW-1:0]  w_pcount_inc;
    logic [7:0]     w_emit_byte;
    logic [LW-1:0]  w_rlen;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;
    assign w_b      = i_item.data_byte;

    // Ring slot arithmetic.
    assign w_wbase = RAW'(RAW'(r_wslot) * RAW'(SLOT_BYTES));
    assign w_wnext = (32'(r_wslot) == RING_SLOTS - 1) ? '0 : SW'(r_wslot + 1'b1);

    // Byte of the short packet being sent.
    always_comb begin
        w_sh_byte = r_sck;
        w_sh_last = 1'b0;
        case (r_idx)
            IW'(0): w_sh_byte = r_sh_cmd;
            IW'(1): w_sh_byte = {7'd0, r_sh_len1};
            IW'(2): begin
                w_sh_byte = r_sh_len1 ? r_sh_pay : r_sck;
                w_sh_last = !r_sh_len1;
            end
            default: w_sh_last = 1'b1;
        endcase
    end

    // Shared CRC unit: received bytes while idle, sent bytes in a short packet.
    always_comb begin
        if (r_state == S_SHORT) begin
            w_crc_in = w_sh_byte;
        end else if (r_phase == PH_DATA) begin
            w_crc_in = r_pcrc ^ w_b;
        end else begin
            w_crc_in = w_b;
        end
    end
    assign w_crc_out = crc8(w_crc_in);

    assign w_tx_next    = (r_tx_count < IW'(SLOT_BYTES)) ? IW'(r_tx_count + 1'b1) : r_tx_count;
    assign w_pcount_inc = (r_pcount < r_flen) ? LW'(r_pcount + 1'b1) : r_pcount;
    assign w_emit_byte  = r_src_last ? w_last_q : w_ring_q;
    assign w_rlen = (w_ring_q > 8'(MAX_PAYLOAD)) ? LW'(MAX_PAYLOAD) : w_ring_q[LW-1:0];
    assign w_ring_raddr = RAW'(r_base + RAW'(r_idx));

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state = r_state;       n_phase = r_phase;       n_pcount = r_pcount;
        n_fcmd = r_fcmd;         n_flen = r_flen;         n_hcrc = r_hcrc;
        n_pcrc = r_pcrc;         n_wslot = r_wslot;       n_rslot = r_rslot;
        n_last_len = r_last_len; n_tx_count = r_tx_count;
        n_ack_code = r_ack_code; n_retx_code = r_retx_code;
        n_sh_cmd = r_sh_cmd;     n_sh_len1 = r_sh_len1;   n_sh_pay = r_sh_pay;
        n_sck = r_sck;           n_err = r_err;           n_acc = r_acc;
        n_src_last = r_src_last; n_idx = r_idx;           n_cnt = r_cnt;
        n_base = r_base;
        n_strobe = 1'b0;
        n_out = '0;
        w_ring_we = 1'b0;
        w_ring_waddr = w_wbase;
        w_ring_wdata = w_b;
        w_last_we = 1'b0;
        w_last_waddr = r_idx[LAW-1:0];
        w_last_wdata = w_sh_byte;

        // Register writes.
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACK_CODE:  n_ack_code = i_cfg_data;
                CFG_RETX_CODE: n_retx_code = i_cfg_data;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.kind)
                        KIND_RX: begin
                            unique case (r_phase)
                                PH_CMD: begin
                                    n_fcmd = w_b;
                                    n_hcrc = w_crc_out;
                                    w_ring_we = 1'b1;
                                    n_phase = PH_LEN;
                                end
                                PH_LEN: begin
                                    if (w_b > 8'(MAX_PAYLOAD)) begin
                                        n_phase = PH_CMD;
                                    end else begin
                                        n_flen = w_b[LW-1:0];
                                        n_pcount = '0;
                                        n_pcrc = '0;
                                        n_hcrc = r_hcrc ^ w_crc_out;
                                        w_ring_we = 1'b1;
                                        w_ring_waddr = RAW'(w_wbase + RAW'(1));
                                        n_phase = (w_b != 8'd0) ? PH_DATA : PH_CHECK;
                                    end
                                end
                                PH_DATA: begin
                                    if (r_pcount < r_flen) begin
                                        w_ring_we = 1'b1;
                                        w_ring_waddr = RAW'(w_wbase + RAW'(r_pcount) + RAW'(2));
                                        n_pcrc = w_crc_out;
                                    end
                                    n_pcount = w_pcount_inc;
                                    if (w_pcount_inc >= r_flen) begin
                                        n_phase = PH_CHECK;
                                    end
                                end
                                PH_CHECK: begin
                                    n_phase = PH_CMD;
                                    if ((r_hcrc ^ r_pcrc) != w_b) begin
                                        // Bad check: ask for a retransmit.
                                        n_sh_cmd = r_retx_code;
                                        n_sh_len1 = 1'b0;
                                        n_sck = '0;
                                        n_idx = '0;
                                        n_err = 1'b1;
                                        n_acc = 1'b0;
                                        n_state = S_SHORT;
                                    end else if (r_fcmd == r_retx_code) begin
                                        // Replay the last packet sent.
                                        n_tx_count = '0;
                                        if (r_last_len == '0) begin
                                            n_strobe = 1'b1;
                                            n_out.run_last = 1'b1;
                                        end else begin
                                            n_src_last = 1'b1;
                                            n_idx = '0;
                                            n_cnt = r_last_len;
                                            n_state = S_FETCH;
                                        end
                                    end else if (w_wnext == r_rslot) begin
                                        // Ring full.
                                        n_strobe = 1'b1;
                                        n_out.run_last = 1'b1;
                                        n_out.error_event = 1'b1;
                                    end else begin
                                        // Store the check byte and acknowledge.
                                        w_ring_we = 1'b1;
                                        w_ring_waddr = RAW'(w_wbase + RAW'(r_flen) + RAW'(2));
                                        n_wslot = w_wnext;
                                        n_sh_cmd = r_ack_code;
                                        n_sh_len1 = 1'b1;
                                        n_sh_pay = r_fcmd;
                                        n_sck = '0;
                                        n_idx = '0;
                                        n_err = 1'b0;
                                        n_acc = 1'b1;
                                        n_state = S_SHORT;
                                    end
                                end
                            endcase
                        end
                        KIND_READ: begin
                            if (r_rslot == r_wslot) begin
                                n_strobe = 1'b1;
                                n_out.run_last = 1'b1;
                                n_out.no_packet = 1'b1;
                            end else begin
                                n_src_last = 1'b0;
                                n_base = RAW'(RAW'(r_rslot) * RAW'(SLOT_BYTES));
                                n_idx = '0;
                                n_cnt = IW'(SLOT_BYTES);
                                n_rslot = (32'(r_rslot) == RING_SLOTS - 1) ? '0
                                        : SW'(r_rslot + 1'b1);
                                n_state = S_FETCH;
                            end
                        end
                        KIND_TX: begin
                            n_strobe = 1'b1;
                            n_out.dest = DEST_LINK;
                            n_out.out_byte = w_b;
                            n_out.run_last = 1'b1;
                            if (r_tx_count < IW'(SLOT_BYTES)) begin
                                w_last_we = 1'b1;
                                w_last_waddr = r_tx_count[LAW-1:0];
                                w_last_wdata = w_b;
                            end
                            n_last_len = w_tx_next;
                            n_tx_count = i_item.tx_end ? '0 : w_tx_next;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHORT: begin
                // One packet byte per cycle, recorded as the last packet sent.
                n_strobe = 1'b1;
                n_out.dest = DEST_LINK;
                n_out.out_byte = w_sh_byte;
                n_sck = r_sck ^ w_crc_out;
                w_last_we = 1'b1;
                n_idx = IW'(r_idx + 1'b1);
                if (w_sh_last) begin
                    n_out.run_last = 1'b1;
                    n_out.error_event = r_err;
                    n_out.frame_accepted = r_acc;
                    n_last_len = IW'(r_idx + 1'b1);
                    n_tx_count = '0;
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Stream one stored byte; a ring frame's length sets the count.
                n_strobe = 1'b1;
                n_out.dest = r_src_last ? DEST_LINK : DEST_APP;
                n_out.out_byte = w_emit_byte;
                if (!r_src_last && r_idx == IW'(1)) begin
                    n_cnt = IW'(IW'(w_rlen) + IW'(3));
                end
                if (r_idx == IW'(r_cnt - 1'b1)) begin
                    n_out.run_last = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = IW'(r_idx + 1'b1);
                    n_state = S_FETCH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;     r_phase <= PH_CMD;    r_pcount <= '0;
            r_fcmd <= '0;          r_flen <= '0;         r_hcrc <= '0;
            r_pcrc <= '0;          r_wslot <= '0;        r_rslot <= '0;
            r_last_len <= '0;      r_tx_count <= '0;
            r_ack_code <= 8'd6;    r_retx_code <= 8'd21;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;       r_phase <= n_phase;       r_pcount <= n_pcount;
            r_fcmd <= n_fcmd;         r_flen <= n_flen;         r_hcrc <= n_hcrc;
            r_pcrc <= n_pcrc;         r_wslot <= n_wslot;       r_rslot <= n_rslot;
            r_last_len <= n_last_len; r_tx_count <= n_tx_count;
            r_ack_code <= n_ack_code; r_retx_code <= n_retx_code;
            r_strobe <= n_strobe;
        end
    end

    // Sequencer payload registers.
    always_ff @(posedge i_clk) begin
        r_sh_cmd <= n_sh_cmd;     r_sh_len1 <= n_sh_len1;   r_sh_pay <= n_sh_pay;
        r_sck <= n_sck;           r_err <= n_err;           r_acc <= n_acc;
        r_src_last <= n_src_last; r_idx <= n_idx;           r_cnt <= n_cnt;
        r_base <= n_base;         r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // Frame ring.
    cplr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (w_ring_waddr),
        .i_wdata (w_ring_wdata),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_q)
    );

    // Last packet sent.
    cplr_ram #(.WIDTH(8), .DEPTH(SLOT_BYTES)) u_last (
        .i_clk   (i_clk),
        .i_we    (w_last_we),
        .i_waddr (w_last_waddr),
        .i_wdata (w_last_wdata),
        .i_raddr (r_idx[LAW-1:0]),
        .o_rdata (w_last_q)
    );

endmodule
